// ===== rtl/sdre_pkg.sv =====
`default_nettype none
package sdre_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;
    localparam int ALPHA_W = 64;
    localparam int NCHARS  = 16;
    localparam int CHUNK_W = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_RADIX_SIZE    = 2'd0;
    localparam cfg_idx_t REG_ALPHABET_LOW  = 2'd1;
    localparam cfg_idx_t REG_ALPHABET_HIGH = 2'd2;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [ALPHA_W-1:0] alpha_t;

    // byte of the alphabet for one digit
    function automatic char_t char_of(alpha_t lo, alpha_t hi, digit_t d);
        alpha_t word;
        word = d[3] ? hi : lo;
        return word[{d[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sdre_alpha_check.sv =====
`default_nettype none
module sdre_alpha_check #(
    parameter int MAX_RADIX = 16
) (
    input  wire sdre_pkg::radix_t radix_size,
    input  wire sdre_pkg::alpha_t alphabet_low,
    input  wire sdre_pkg::alpha_t alphabet_high,
    output logic                  ok
);

    sdre_pkg::char_t chars [sdre_pkg::NCHARS];
    logic            clash;

    always_comb
    begin
        clash = 1'b0;
        for (int i = 0; i < sdre_pkg::NCHARS; i++)
        begin
            chars[i] = sdre_pkg::char_of(alphabet_low, alphabet_high,
                                         sdre_pkg::DIGIT_W'(i));
        end
        for (int i = 0; i < sdre_pkg::NCHARS; i++)
        begin
            if (sdre_pkg::RADIX_W'(i) < radix_size)
            begin
                if (chars[i] == sdre_pkg::CH_MINUS || chars[i] == sdre_pkg::CH_PLUS)
                    clash = 1'b1;
                for (int j = i + 1; j < sdre_pkg::NCHARS; j++)
                begin
                    if (sdre_pkg::RADIX_W'(j) < radix_size && chars[j] == chars[i])
                        clash = 1'b1;
                end
            end
        end
        ok = (radix_size >= sdre_pkg::MIN_RADIX)
          && (radix_size <= sdre_pkg::RADIX_W'(MAX_RADIX))
          && !clash;
    end

endmodule
`default_nettype wire

// ===== rtl/sdre_div_step.sv =====
`default_nettype none
module sdre_div_step (
    input  wire sdre_pkg::radix_t             radix,
    input  wire sdre_pkg::digit_t             rem_in,
    input  wire logic [sdre_pkg::CHUNK_W-1:0] chunk,
    output sdre_pkg::digit_t                  rem_out,
    output logic [sdre_pkg::CHUNK_W-1:0]      quot
);

    // four restoring steps, remainder stays below the radix
    logic [sdre_pkg::RADIX_W-1:0] t;
    sdre_pkg::digit_t             r;

    always_comb
    begin
        r    = rem_in;
        quot = '0;
        t    = '0;
        for (int k = sdre_pkg::CHUNK_W - 1; k >= 0; k--)
        begin
            t = {r, chunk[k]};
            if (t >= radix)
            begin
                quot[k] = 1'b1;
                t       = t - radix;
            end
            r = t[sdre_pkg::DIGIT_W-1:0];
        end
        rem_out = r;
    end

endmodule
`default_nettype wire

// ===== rtl/sdre_digit_buf.sv =====
`default_nettype none
module sdre_digit_buf #(
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire sdre_pkg::digit_t         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output sdre_pkg::digit_t              rdata
);

    sdre_pkg::digit_t mem [DEPTH];
    sdre_pkg::digit_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/signed_radix_digit_emitter_unit.sv =====
`default_nettype none
// writes a signed integer as text in a configured radix, one character per output
// word. the alphabet (radix_size characters, 2..MAX_RADIX, from alphabet_low and
// alphabet_high) must hold no repeats and no '+' or '-'; otherwise one error word
// (char 0, last_char and bad_alphabet set) comes out. a negative value yields '-'
// first, then the digits most significant first, last_char on the final digit.
// digits come out of a shared divide unit that retires four quotient bits per cycle;
// each digit is stored in a small buffer and read back in reverse, one fetch state
// and one emit state per character, the emit waiting for the output register to
// be free. in_ready is high only while the sequencer idles.
module signed_radix_digit_emitter_unit #(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire sdre_pkg::cfg_idx_t   cfg_index,
    input  wire sdre_pkg::alpha_t     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                char_out,
    output logic                      last_char,
    output logic                      bad_alphabet
);

    localparam int NSTEP = (VALUE_WIDTH + sdre_pkg::CHUNK_W - 1) / sdre_pkg::CHUNK_W;
    localparam int PW    = NSTEP * sdre_pkg::CHUNK_W;
    localparam int AW    = $clog2(VALUE_WIDTH);
    localparam int SW    = $clog2(NSTEP);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_SIGN  = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_ERR   = 6'b100000
    } state_t;

    // configuration registers
    sdre_pkg::radix_t radix_reg;
    sdre_pkg::alpha_t alpha_lo_reg;
    sdre_pkg::alpha_t alpha_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= '0;
            alpha_lo_reg <= '0;
            alpha_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdre_pkg::REG_RADIX_SIZE:    radix_reg    <= cfg_data[sdre_pkg::RADIX_W-1:0];
                sdre_pkg::REG_ALPHABET_LOW:  alpha_lo_reg <= cfg_data;
                sdre_pkg::REG_ALPHABET_HIGH: alpha_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic alpha_ok;

    sdre_alpha_check #(
        .MAX_RADIX (MAX_RADIX)
    ) u_check (
        .radix_size    (radix_reg),
        .alphabet_low  (alpha_lo_reg),
        .alphabet_high (alpha_hi_reg),
        .ok            (alpha_ok)
    );

    // magnitude of the incoming value, most negative value included
    logic [VALUE_WIDTH-1:0] raw;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;

    assign raw    = value[VALUE_WIDTH-1:0];
    assign in_neg = raw[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~raw + 1'b1) : raw;

    // sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [PW-1:0]          mag_reg, mag_next;
    sdre_pkg::digit_t       rem_reg, rem_next;
    logic [SW-1:0]          step_reg, step_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   neg_reg, neg_next;

    // shared divide unit on the top chunk of the shifting dividend
    sdre_pkg::digit_t             div_rem;
    logic [sdre_pkg::CHUNK_W-1:0] div_quot;
    logic [PW-1:0]                shifted;

    sdre_div_step u_div (
        .radix   (radix_reg),
        .rem_in  (rem_reg),
        .chunk   (mag_reg[PW-1 -: sdre_pkg::CHUNK_W]),
        .rem_out (div_rem),
        .quot    (div_quot)
    );

    assign shifted = {mag_reg[PW-sdre_pkg::CHUNK_W-1:0], div_quot};

    // digit buffer, least significant digit at address 0
    logic             buf_we;
    logic             buf_re;
    sdre_pkg::digit_t buf_rdata;

    sdre_digit_buf #(
        .DEPTH (VALUE_WIDTH)
    ) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (cnt_reg),
        .wdata (div_rem),
        .re    (buf_re),
        .raddr (idx_reg),
        .rdata (buf_rdata)
    );

    // output word register
    logic                 out_valid_reg, out_valid_next;
    sdre_pkg::char_t      char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 bad_reg, bad_next;
    logic                 out_free;
    logic                 out_load;
    logic                 step_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign step_done = (step_reg == SW'(NSTEP - 1));
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        buf_we     = 1'b0;
        buf_re     = 1'b0;
        out_load   = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next  = PW'(in_mag);
                    neg_next  = in_neg;
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = '0;
                    state_next = alpha_ok ? ST_DIV : ST_ERR;
                end
            end
            ST_DIV:
            begin
                mag_next  = shifted;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (step_done)
                begin
                    // digit complete: store it, start over on the quotient
                    buf_we    = 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = cnt_reg + 1'b1;
                    if (shifted == '0)
                    begin
                        idx_next   = cnt_reg;
                        state_next = ST_SIGN;
                    end
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                    state_next = ST_FETCH;
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = sdre_pkg::CH_MINUS;
                    last_next  = 1'b0;
                    bad_next   = 1'b0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                buf_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    char_next = sdre_pkg::char_of(alpha_lo_reg, alpha_hi_reg, buf_rdata);
                    last_next = (idx_reg == '0);
                    bad_next  = 1'b0;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = '0;
                    last_next  = 1'b1;
                    bad_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign out_valid    = out_valid_reg;
    assign char_out     = char_reg;
    assign last_char    = last_reg;
    assign bad_alphabet = bad_reg;

endmodule
`default_nettype wire

// ===== test/sdre_checker.sv =====
`timescale 1ns / 100ps
// watches the config port and both channels, keeps its own text predictor and
// compares every output word with the oldest expected one
module sdre_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire sdre_pkg::cfg_idx_t   cfg_index,
    input  wire sdre_pkg::alpha_t     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic signed [31:0]   value,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [7:0]           char_out,
    input  wire logic                 last_char,
    input  wire logic                 bad_alphabet,
    output int                        mismatches,
    output int                        words_due
);
    import sdre_pkg::*;

    typedef struct packed {
        char_t ch;
        logic  last;
        logic  bad;
    } text_word_t;

    text_word_t expected_text[$];
    radix_t     base_reg;
    alpha_t     lo_reg;
    alpha_t     hi_reg;

    function automatic char_t glyph(int d);
        alpha_t w;
        w = (d < 8) ? lo_reg : hi_reg;
        return w[(d % 8) * 8 +: 8];
    endfunction

    function automatic bit alphabet_usable();
        int n;
        n = int'(base_reg);
        if (n < int'(MIN_RADIX) || n > NCHARS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (glyph(i) == CH_MINUS || glyph(i) == CH_PLUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (glyph(j) == glyph(i))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue up the words one value should turn into
    task automatic predict_text(logic signed [31:0] v);
        logic [32:0] mag;
        logic [32:0] base;
        int          digs[33];
        int          nd;
        if (!alphabet_usable())
        begin
            expected_text.push_back('{ch: '0, last: 1'b1, bad: 1'b1});
            return;
        end
        base = 33'(base_reg);
        // one bit wider so the most negative value has a magnitude
        mag = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
        nd = 0;
        do
        begin
            digs[nd] = int'(mag % base);
            mag = mag / base;
            nd++;
        end
        while (mag != 0);
        if (v[31])
            expected_text.push_back('{ch: CH_MINUS, last: 1'b0, bad: 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            expected_text.push_back('{ch: glyph(digs[k]), last: (k == 0), bad: 1'b0});
    endtask

    task automatic flag_error(string msg);
        mismatches++;
        $display("%0t ns: text check: %s", $time, msg);
    endtask

    task automatic check_word();
        text_word_t want;
        if (expected_text.size() == 0)
        begin
            flag_error($sformatf("word char 0x%02h arrived with nothing expected", char_out));
            return;
        end
        want = expected_text.pop_front();
        if (char_out !== want.ch)
            flag_error($sformatf("char_out 0x%02h, expected 0x%02h", char_out, want.ch));
        if (last_char !== want.last)
            flag_error($sformatf("last_char %b, expected %b", last_char, want.last));
        if (bad_alphabet !== want.bad)
            flag_error($sformatf("bad_alphabet %b, expected %b", bad_alphabet, want.bad));
    endtask

    initial
    begin
        mismatches = 0;
        words_due  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg = '0;
            lo_reg   = '0;
            hi_reg   = '0;
            expected_text.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_RADIX_SIZE)
                    base_reg = cfg_data[RADIX_W-1:0];
                else if (cfg_index == REG_ALPHABET_LOW)
                    lo_reg = cfg_data;
                else if (cfg_index == REG_ALPHABET_HIGH)
                    hi_reg = cfg_data;
            end
            if (in_valid && in_ready)
                predict_text(value);
            if (out_valid && out_ready)
                check_word();
        end
        words_due = expected_text.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the signed radix digit emitter; all checking lives
// in the checker instance beside the block
module tb_top;
    import sdre_pkg::*;

    // index with no register behind it, written once to see it is ignored
    localparam cfg_idx_t REG_UNMAPPED = 2'd3;
    // cycles to let pass once the last word is back, before touching config
    localparam int SETTLE_CYCLES = 8;
    // generous ceiling for the whole run, even an all-binary one with stalls
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 22;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_idx_t           cfg_index;
    alpha_t             cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         char_out;
    logic               last_char;
    logic               bad_alphabet;

    int mismatches;
    int words_due;
    int cycles;
    // when set, neither side idles
    bit calm;

    signed_radix_digit_emitter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_out     (char_out),
        .last_char    (last_char),
        .bad_alphabet (bad_alphabet)
    );

    sdre_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_out     (char_out),
        .last_char    (last_char),
        .bad_alphabet (bad_alphabet),
        .mismatches   (mismatches),
        .words_due    (words_due)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: drops ready about 22 percent of the time unless calm
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // watchdog on a cycle counter
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // bytes first..first+7 of a string, first one in the low byte
    function automatic alpha_t pack_chars(string s, int first);
        alpha_t w;
        w = '0;
        for (int i = 0; i < 8; i++)
            if (first + i < s.len())
                w[8*i +: 8] = s[first + i];
        return w;
    endfunction

    // mostly full-range values, with small ones and the extremes mixed in
    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: v = 32'sh0000_0000;
                    1: v = 32'sh0000_0001;
                    2: v = 32'shffff_ffff;
                    3: v = 32'sh7fff_ffff;
                    default: v = 32'sh8000_0000;
                endcase
            end
            1: v = $urandom_range(50);
            2: v = -$signed({1'b0, 31'($urandom_range(1, 50))});
            3:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // present one word and hold it until it is taken; may idle first
    task automatic send_value(logic signed [31:0] v);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait until every expected word has come back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller lowers the enable after the batch
    task automatic write_reg(cfg_idx_t idx, alpha_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // full alphabet setup, only ever with the block idle
    task automatic load_alphabet(alpha_t radix_word, alpha_t lo, alpha_t hi);
        settle();
        write_reg(REG_RADIX_SIZE, radix_word);
        write_reg(REG_ALPHABET_LOW, lo);
        write_reg(REG_ALPHABET_HIGH, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random distinct alphabet; a spoiled one breaks it in one of the known ways
    task automatic random_phase(int items, bit spoil, bit mid_pause);
        logic [255:0] taken;
        char_t        glyphs[16];
        char_t        b;
        alpha_t       lo;
        alpha_t       hi;
        alpha_t       radix_word;
        int           n;
        int           i;
        int           j;
        taken = '0;
        taken[CH_PLUS]  = 1'b1;
        taken[CH_MINUS] = 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            do
                b = char_t'($urandom_range(255));
            while (taken[b]);
            taken[b] = 1'b1;
            glyphs[k] = b;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(2, 16);
        if (spoil)
        begin
            i = $urandom_range(n - 2);
            j = $urandom_range(i + 1, n - 1);
            case ($urandom_range(3))
                0: glyphs[j] = glyphs[i];
                1: glyphs[j] = CH_PLUS;
                2: glyphs[j] = CH_MINUS;
                default: n = ($urandom_range(1)) ? $urandom_range(1) : $urandom_range(17, 31);
            endcase
        end
        else if (n < 16 && $urandom_range(2) == 0)
        begin
            // junk past the end of the alphabet must not matter
            j = $urandom_range(n, 15);
            case ($urandom_range(2))
                0: glyphs[j] = CH_PLUS;
                1: glyphs[j] = CH_MINUS;
                default: glyphs[j] = glyphs[0];
            endcase
        end
        for (int k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = glyphs[k];
            hi[8*k +: 8] = glyphs[k + 8];
        end
        // upper bits of the radix write are don't-care
        radix_word = $urandom_range(1) ? {$urandom, $urandom} : '0;
        radix_word[RADIX_W-1:0] = n[RADIX_W-1:0];
        load_alphabet(radix_word, lo, hi);
        for (int k = 0; k < items; k++)
        begin
            // sender holds off until the block has drained completely
            if (mid_pause && k == items / 2)
                settle();
            send_value(rand_value());
        end
    endtask

    initial
    begin
        string dec;
        string hexa;
        bit    spoil;
        dec  = "0123456789";
        hexa = "0123456789abcdef";
        calm = 1'b0;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RADIX_SIZE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        value     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet has size zero, so every value is an error word
        send_value(32'sd0);
        send_value(-32'sd5);

        // decimal, with a write to the unmapped index that must change nothing
        load_alphabet(64'd10, pack_chars(dec, 0), pack_chars(dec, 8));
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(posedge clk);
        send_value(32'sd0);
        send_value(32'sd7);
        send_value(-32'sd7);
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        send_value(-32'sd1);
        send_value(32'sd10);
        send_value(32'sd1000000);

        // binary: longest texts
        load_alphabet(64'd2, pack_chars("01", 0), '0);
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        send_value(32'sd5);

        // full sixteen-character alphabet
        load_alphabet(64'd16, pack_chars(hexa, 0), pack_chars(hexa, 8));
        send_value(32'sh7fff_ffff);
        send_value(-32'sd1);
        send_value(32'sd255);

        // sizes out of range: above the maximum, the top code, and one
        load_alphabet(64'd17, pack_chars(hexa, 0), pack_chars(hexa, 8));
        send_value(32'sd99);
        load_alphabet(64'd31, pack_chars(hexa, 0), pack_chars(hexa, 8));
        send_value(-32'sd99);
        load_alphabet(64'd1, pack_chars(hexa, 0), pack_chars(hexa, 8));
        send_value(32'sd3);

        // repeated character, plus sign, minus sign inside the alphabet
        load_alphabet(64'd4, pack_chars("0120", 0), '0);
        send_value(32'sd6);
        load_alphabet(64'd4, pack_chars("01+3", 0), '0);
        send_value(32'sd6);
        load_alphabet(64'd4, pack_chars("0-23", 0), '0);
        send_value(32'sd6);

        // a zero byte is an ordinary digit
        load_alphabet(64'd3, {40'd0, 8'h62, 8'h61, 8'h00}, '0);
        send_value(32'sd9);
        send_value(-32'sd4);

        // a minus just past the end of the alphabet is harmless
        load_alphabet(64'd10, pack_chars(dec, 0), pack_chars("89-+++++", 0));
        send_value(-32'sd123);

        // random alphabets; a calm stretch in the middle, one drain mid-phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            calm  = (ph >= 8 && ph < 12);
            spoil = (ph % 7 == 3);
            random_phase(spoil ? 5 : 20, spoil, ph == 5);
        end
        calm = 1'b0;

        settle();
        if (mismatches == 0 && words_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
